### design/spcd_pkg.sv
// ----------------------------------------------------------------------------
// Steering PD with corner detection: shared definitions
// Register map, reset values, event codes and the reciprocal constants used
// for the divide-by-five and divide-by-ten means.
// ----------------------------------------------------------------------------
`default_nettype none

package spcd_pkg;

	// Configuration port geometry.
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	// Register field widths.
	localparam int THRESH_W = 11;
	localparam int GAIN_W   = 16;
	localparam int LIMIT_W  = 15;

	// Steering angle width on the result.
	localparam int ANGLE_W = 16;

	// Register indexes on the configuration port.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_DEAD_ZONE   = 3'd0,
		REG_KP_STRAIGHT = 3'd1,
		REG_KP_CORNER   = 3'd2,
		REG_KD_GAIN     = 3'd3,
		REG_ANGLE_LIMIT = 3'd4,
		REG_ANGLE_SLEW  = 3'd5,
		REG_ENTER_THR   = 3'd6,
		REG_EXIT_THR    = 3'd7
	} cfg_reg_t;

	// Register reset values.
	localparam logic [THRESH_W-1:0] DEAD_ZONE_RST   = 11'd0;
	localparam logic [GAIN_W-1:0]   KP_STRAIGHT_RST = 16'd256;
	localparam logic [GAIN_W-1:0]   KP_CORNER_RST   = 16'd256;
	localparam logic [GAIN_W-1:0]   KD_GAIN_RST     = 16'd0;
	localparam logic [LIMIT_W-1:0]  ANGLE_LIMIT_RST = 15'd1000;
	localparam logic [LIMIT_W-1:0]  ANGLE_SLEW_RST  = 15'd32767;
	localparam logic [THRESH_W-1:0] ENTER_THR_RST   = 11'd0;
	localparam logic [THRESH_W-1:0] EXIT_THR_RST    = 11'd0;

	// Integral scale event reported with each result.
	typedef enum logic [1:0] {
		SCALE_NONE = 2'd0,
		SCALE_DIV3 = 2'd1,
		SCALE_MUL3 = 2'd2
	} scale_t;

	// Reciprocals for magnitudes below 2^18: floor(m / 5) and floor(m / 10).
	localparam int          RECIP_W       = 16;
	localparam logic [15:0] RECIP5        = 16'd52429;
	localparam int          RECIP5_SHIFT  = 18;
	localparam logic [15:0] RECIP10       = 16'd52429;
	localparam int          RECIP10_SHIFT = 19;

endpackage

`default_nettype wire

### design/steering_pd_with_corner_detect.sv
// ----------------------------------------------------------------------------
// Steering PD controller with corner detection
// Per frame: 5-sample means of the middle and far errors, a slow far
// estimate, a hysteresis corner flag, and a dead-zone PD steering angle that
// is clamped and slew limited.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Beat content (low bits first)
// s_*       in   tdata: mid_dir, far_dir
// m_*       out  tdata: steer_angle, in_corner, integral_scale, mid_filtered,
//                       mid_filtered_diff, far_filtered, far_slow_diff
// cfg_*     in   cfg_index selects a register, cfg_data carries the value
//
// One beat can be taken every cycle while m_tready does not stall the output.
// The pipeline is input stage, mean stage, multiply stage and output register;
// the frame-to-frame state lives in the stage that uses it.
// Reset clears the histories, the previous means, the corner flag and the
// previous angle, and loads the register defaults.
// A stall on m_tready fills the stages in turn; s_tready drops once all are full.
// ----------------------------------------------------------------------------
`default_nettype none

module steering_pd_with_corner_detect #(
	parameter int DIR_WIDTH      = 12,
	parameter int GAIN_FRAC_BITS = 8
) (
	input  wire                                        clk,
	input  wire                                        arst_n,
	// Input beats.
	input  wire                                        s_tvalid,
	output logic                                       s_tready,
	// mid_dir, far_dir
	input  wire  [((2*DIR_WIDTH+7)/8)*8-1:0]           s_tdata,
	// Result beats.
	output logic                                       m_tvalid,
	input  wire                                        m_tready,
	// steer_angle, in_corner, integral_scale, mid_filtered, mid_filtered_diff,
	// far_filtered, far_slow_diff
	output logic [((21+4*DIR_WIDTH+7)/8)*8-1:0]        m_tdata,
	// Register writes.
	input  wire                                        cfg_valid,
	output logic                                       cfg_ready,
	input  wire  [spcd_pkg::CFG_INDEX_W-1:0]           cfg_index,
	input  wire  [spcd_pkg::CFG_DATA_W-1:0]            cfg_data
);

	localparam int DW         = DIR_WIDTH;
	localparam int SW         = DW + 3;                       // five-sample sums
	localparam int EW         = ((DW > spcd_pkg::THRESH_W) ? DW : spcd_pkg::THRESH_W) + 2;
	localparam int AW         = DW + 19;                      // PD accumulator
	localparam int OUT_BITS   = 21 + 4 * DW;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
	localparam int SLW        = spcd_pkg::ANGLE_W + 2;        // slew arithmetic
	localparam logic signed [AW-1:0] ROUND_BIAS = AW'((1 << GAIN_FRAC_BITS) - 1);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [spcd_pkg::THRESH_W-1:0] dead_zone_q;
	logic [spcd_pkg::GAIN_W-1:0]   kp_straight_q;
	logic [spcd_pkg::GAIN_W-1:0]   kp_corner_q;
	logic [spcd_pkg::GAIN_W-1:0]   kd_gain_q;
	logic [spcd_pkg::LIMIT_W-1:0]  angle_limit_q;
	logic [spcd_pkg::LIMIT_W-1:0]  angle_slew_q;
	logic [spcd_pkg::THRESH_W-1:0] enter_thr_q;
	logic [spcd_pkg::THRESH_W-1:0] exit_thr_q;

	assign cfg_ready = 1'b1;

	// Register writes; upper data bits beyond a field are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_zone_q   <= spcd_pkg::DEAD_ZONE_RST;
			kp_straight_q <= spcd_pkg::KP_STRAIGHT_RST;
			kp_corner_q   <= spcd_pkg::KP_CORNER_RST;
			kd_gain_q     <= spcd_pkg::KD_GAIN_RST;
			angle_limit_q <= spcd_pkg::ANGLE_LIMIT_RST;
			angle_slew_q  <= spcd_pkg::ANGLE_SLEW_RST;
			enter_thr_q   <= spcd_pkg::ENTER_THR_RST;
			exit_thr_q    <= spcd_pkg::EXIT_THR_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (spcd_pkg::cfg_reg_t'(cfg_index))
				spcd_pkg::REG_DEAD_ZONE:   dead_zone_q   <= cfg_data[spcd_pkg::THRESH_W-1:0];
				spcd_pkg::REG_KP_STRAIGHT: kp_straight_q <= cfg_data[spcd_pkg::GAIN_W-1:0];
				spcd_pkg::REG_KP_CORNER:   kp_corner_q   <= cfg_data[spcd_pkg::GAIN_W-1:0];
				spcd_pkg::REG_KD_GAIN:     kd_gain_q     <= cfg_data[spcd_pkg::GAIN_W-1:0];
				spcd_pkg::REG_ANGLE_LIMIT: angle_limit_q <= cfg_data[spcd_pkg::LIMIT_W-1:0];
				spcd_pkg::REG_ANGLE_SLEW:  angle_slew_q  <= cfg_data[spcd_pkg::LIMIT_W-1:0];
				spcd_pkg::REG_ENTER_THR:   enter_thr_q   <= cfg_data[spcd_pkg::THRESH_W-1:0];
				spcd_pkg::REG_EXIT_THR:    exit_thr_q    <= cfg_data[spcd_pkg::THRESH_W-1:0];
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Pipeline flow control: each stage loads when the next one can take
	// its content.
	// ------------------------------------------------------------------
	logic valid_s1, valid_s2, valid_s3, out_valid_q;
	logic ready_s2, ready_s3, ready_out;
	logic load_s1, load_s2, load_s3, load_out;

	assign ready_out = !out_valid_q || m_tready;
	assign ready_s3  = !valid_s3 || ready_out;
	assign ready_s2  = !valid_s2 || ready_s3;
	assign s_tready  = !valid_s1 || ready_s2;

	assign load_s1  = s_tvalid && s_tready;
	assign load_s2  = valid_s1 && ready_s2;
	assign load_s3  = valid_s2 && ready_s3;
	assign load_out = valid_s3 && ready_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready)  valid_s1    <= s_tvalid;
			if (ready_s2)  valid_s2    <= valid_s1;
			if (ready_s3)  valid_s3    <= valid_s2;
			if (ready_out) out_valid_q <= valid_s3;
		end
	end

	// ------------------------------------------------------------------
	// Input stage: histories, five-sample sums and the dead zone
	// ------------------------------------------------------------------
	logic signed [DW-1:0] mid_in, far_in;
	// Only the taps still needed after this beat's shift are kept.
	logic signed [DW-1:0] mid_hist_q [4];
	logic signed [DW-1:0] far_hist_q [9];
	logic signed [SW-1:0] mid_sum_c, far_sum_c, old_sum_c;
	logic signed [EW-1:0] mid_w, dz_w, mag_w, err_w;
	logic signed [SW-1:0] mid_sum_s1, far_sum_s1, old_sum_s1;
	logic signed [DW-1:0] err_s1;

	assign mid_in = signed'(s_tdata[DW-1:0]);
	assign far_in = signed'(s_tdata[2*DW-1:DW]);

	assign mid_sum_c = SW'(mid_in) + SW'(mid_hist_q[0]) + SW'(mid_hist_q[1])
		+ SW'(mid_hist_q[2]) + SW'(mid_hist_q[3]);
	assign far_sum_c = SW'(far_in) + SW'(far_hist_q[0]) + SW'(far_hist_q[1])
		+ SW'(far_hist_q[2]) + SW'(far_hist_q[3]);
	assign old_sum_c = SW'(far_hist_q[4]) + SW'(far_hist_q[5]) + SW'(far_hist_q[6])
		+ SW'(far_hist_q[7]) + SW'(far_hist_q[8]);

	// Dead zone on the raw middle error: shrink toward zero, or zero below it.
	always_comb begin
		mid_w = EW'(mid_in);
		dz_w  = signed'(EW'(dead_zone_q));
		mag_w = (mid_w < 0) ? -mid_w : mid_w;
		if (mag_w >= dz_w) begin
			err_w = (mid_w > 0) ? (mid_w - dz_w) : (mid_w + dz_w);
		end else begin
			err_w = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) mid_hist_q[i] <= '0;
			for (int i = 0; i < 9; i++) far_hist_q[i] <= '0;
		end else if (load_s1) begin
			mid_hist_q[0] <= mid_in;
			for (int i = 1; i < 4; i++) mid_hist_q[i] <= mid_hist_q[i-1];
			far_hist_q[0] <= far_in;
			for (int i = 1; i < 9; i++) far_hist_q[i] <= far_hist_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			mid_sum_s1 <= mid_sum_c;
			far_sum_s1 <= far_sum_c;
			old_sum_s1 <= old_sum_c;
			err_s1     <= DW'(err_w);
		end
	end

	// ------------------------------------------------------------------
	// Mean stage: divisions truncated toward zero by reciprocal multiply
	// on the magnitude, then the frame-to-frame differences.
	// ------------------------------------------------------------------
	logic [SW-1:0]                    mid_abs, far_abs, old_abs;
	logic [SW+spcd_pkg::RECIP_W-1:0]  mid_prod, far_prod, old_prod;
	logic signed [DW-1:0]             mid_quo, far_quo, old_quo;
	logic signed [DW-1:0]             mid_mean_c, far_mean_c, old_div_c;
	logic signed [DW-1:0]             far_half_c, far_slow_c;
	logic signed [DW:0]               mid_diff_c, far_diff_c, slow_diff_c;
	logic signed [DW-1:0]             mid_mean_prev_q, far_mean_prev_q, far_slow_prev_q;
	logic signed [DW-1:0]             mid_mean_s2, far_mean_s2, err_s2;
	logic signed [DW:0]               mid_diff_s2, far_diff_s2, slow_diff_s2;

	always_comb begin
		mid_abs  = (mid_sum_s1 < 0) ? SW'(-mid_sum_s1) : SW'(mid_sum_s1);
		far_abs  = (far_sum_s1 < 0) ? SW'(-far_sum_s1) : SW'(far_sum_s1);
		old_abs  = (old_sum_s1 < 0) ? SW'(-old_sum_s1) : SW'(old_sum_s1);
		mid_prod = mid_abs * spcd_pkg::RECIP5;
		far_prod = far_abs * spcd_pkg::RECIP5;
		old_prod = old_abs * spcd_pkg::RECIP10;
		mid_quo  = signed'(DW'(mid_prod >> spcd_pkg::RECIP5_SHIFT));
		far_quo  = signed'(DW'(far_prod >> spcd_pkg::RECIP5_SHIFT));
		old_quo  = signed'(DW'(old_prod >> spcd_pkg::RECIP10_SHIFT));
		mid_mean_c = (mid_sum_s1 < 0) ? -mid_quo : mid_quo;
		far_mean_c = (far_sum_s1 < 0) ? -far_quo : far_quo;
		old_div_c  = (old_sum_s1 < 0) ? -old_quo : old_quo;
		// Halving toward zero: bias negative values by one before the shift.
		far_half_c = (far_mean_c + signed'(DW'(far_mean_c < 0))) >>> 1;
		far_slow_c = far_half_c + old_div_c;
		mid_diff_c  = (DW+1)'(mid_mean_c) - (DW+1)'(mid_mean_prev_q);
		far_diff_c  = (DW+1)'(far_mean_c) - (DW+1)'(far_mean_prev_q);
		slow_diff_c = (DW+1)'(far_slow_c) - (DW+1)'(far_slow_prev_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_mean_prev_q <= '0;
			far_mean_prev_q <= '0;
			far_slow_prev_q <= '0;
		end else if (load_s2) begin
			mid_mean_prev_q <= mid_mean_c;
			far_mean_prev_q <= far_mean_c;
			far_slow_prev_q <= far_slow_c;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			mid_mean_s2  <= mid_mean_c;
			far_mean_s2  <= far_mean_c;
			mid_diff_s2  <= mid_diff_c;
			far_diff_s2  <= far_diff_c;
			slow_diff_s2 <= slow_diff_c;
			err_s2       <= err_s1;
		end
	end

	// ------------------------------------------------------------------
	// Multiply stage: corner hysteresis, gain select and the PD sum
	// ------------------------------------------------------------------
	logic                          corner_q, corner_c;
	spcd_pkg::scale_t              scale_c;
	logic signed [EW-1:0]          fm_w, en_w, ex_w;
	logic [spcd_pkg::GAIN_W-1:0]   kp_sel;
	logic signed [DW+16:0]         p_kp;
	logic signed [DW+17:0]         p_kd;
	logic signed [AW-1:0]          acc_c;
	logic signed [AW-1:0]          acc_s3;
	logic                          corner_s3;
	spcd_pkg::scale_t              scale_s3;
	logic signed [DW-1:0]          mid_mean_s3, far_mean_s3;
	logic signed [DW:0]            mid_diff_s3, slow_diff_s3;

	// Enter on a large growing far mean, leave on a small shrinking one.
	always_comb begin
		fm_w     = EW'(far_mean_s2);
		en_w     = signed'(EW'(enter_thr_q));
		ex_w     = signed'(EW'(exit_thr_q));
		corner_c = corner_q;
		scale_c  = spcd_pkg::SCALE_NONE;
		if (!corner_q) begin
			if ((far_diff_s2 > 0 && fm_w > en_w) || (far_diff_s2 < 0 && fm_w < -en_w)) begin
				corner_c = 1'b1;
				scale_c  = spcd_pkg::SCALE_DIV3;
			end
		end else begin
			if ((far_diff_s2 < 0 && fm_w < ex_w && fm_w > 0) ||
				(far_diff_s2 > 0 && fm_w > -ex_w && fm_w < 0)) begin
				corner_c = 1'b0;
				scale_c  = spcd_pkg::SCALE_MUL3;
			end
		end
	end

	assign kp_sel = corner_c ? kp_corner_q : kp_straight_q;
	assign p_kp   = err_s2 * signed'({1'b0, kp_sel});
	assign p_kd   = mid_diff_s2 * signed'({1'b0, kd_gain_q});
	assign acc_c  = AW'(p_kp) + AW'(p_kd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_q <= 1'b0;
		end else if (load_s3) begin
			corner_q <= corner_c;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s3) begin
			acc_s3       <= acc_c;
			corner_s3    <= corner_c;
			scale_s3     <= scale_c;
			mid_mean_s3  <= mid_mean_s2;
			far_mean_s3  <= far_mean_s2;
			mid_diff_s3  <= mid_diff_s2;
			slow_diff_s3 <= slow_diff_s2;
		end
	end

	// ------------------------------------------------------------------
	// Output stage: scale down toward zero, clamp, then slew limit
	// ------------------------------------------------------------------
	logic signed [AW-1:0]                 angle_raw, lim_w;
	logic signed [spcd_pkg::ANGLE_W-1:0]  angle_clamp, angle_c, angle_prev_q;
	logic signed [SLW-1:0]                step_w, slew_w;
	logic signed [spcd_pkg::ANGLE_W-1:0]  steer_q;
	logic                                 corner_out_q;
	spcd_pkg::scale_t                     scale_out_q;
	logic signed [DW-1:0]                 mid_mean_q, far_mean_q;
	logic signed [DW:0]                   mid_diff_q, slow_diff_q;

	always_comb begin
		angle_raw = (acc_s3 + ((acc_s3 < 0) ? ROUND_BIAS : AW'(0))) >>> GAIN_FRAC_BITS;
		lim_w     = signed'(AW'(angle_limit_q));
		if (angle_raw > lim_w) begin
			angle_clamp = spcd_pkg::ANGLE_W'(lim_w);
		end else if (angle_raw < -lim_w) begin
			angle_clamp = spcd_pkg::ANGLE_W'(-lim_w);
		end else begin
			angle_clamp = spcd_pkg::ANGLE_W'(angle_raw);
		end
		step_w = SLW'(angle_clamp) - SLW'(angle_prev_q);
		slew_w = signed'(SLW'(angle_slew_q));
		if (step_w > slew_w) begin
			angle_c = spcd_pkg::ANGLE_W'(SLW'(angle_prev_q) + slew_w);
		end else if (step_w < -slew_w) begin
			angle_c = spcd_pkg::ANGLE_W'(SLW'(angle_prev_q) - slew_w);
		end else begin
			angle_c = angle_clamp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_prev_q <= '0;
		end else if (load_out) begin
			angle_prev_q <= angle_c;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			steer_q      <= angle_c;
			corner_out_q <= corner_s3;
			scale_out_q  <= scale_s3;
			mid_mean_q   <= mid_mean_s3;
			mid_diff_q   <= mid_diff_s3;
			far_mean_q   <= far_mean_s3;
			slow_diff_q  <= slow_diff_s3;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_W'({slow_diff_q, far_mean_q, mid_diff_q, mid_mean_q,
		scale_out_q, corner_out_q, steer_q});

endmodule

`default_nettype wire

### design/spcd_checker.sv
// ----------------------------------------------------------------------------
// Steering PD with corner detection: port checker
// Watches the result channel for a held beat during stalls and for result
// fields that agree with each other.
// ----------------------------------------------------------------------------
`default_nettype none

module spcd_checker #(
	parameter int DIR_WIDTH = 12
) (
	input wire                                 clk,
	input wire                                 arst_n,
	input wire                                 m_tvalid,
	input wire                                 m_tready,
	input wire [((21+4*DIR_WIDTH+7)/8)*8-1:0]  m_tdata
);

	logic [15:0] steer;
	logic        in_corner;
	logic [1:0]  scale;

	assign steer     = m_tdata[15:0];
	assign in_corner = m_tdata[16];
	assign scale     = m_tdata[18:17];

	// A stalled result beat stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	// A stalled result beat keeps its content.
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result beat changed while stalled");

	// Entering a corner reports divide, leaving reports multiply.
	a_scale_matches_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && scale != spcd_pkg::SCALE_NONE |->
			(in_corner == (scale == spcd_pkg::SCALE_DIV3)))
		else $error("integral scale event disagrees with corner flag");

	// The unused scale code never appears.
	a_scale_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(scale[1] && scale[0]))
		else $error("undefined integral scale code");

	// Clamp and slew keep the angle inside the symmetric range.
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> steer != 16'h8000)
		else $error("steering angle outside the symmetric range");

endmodule

bind steering_pd_with_corner_detect spcd_checker #(
	.DIR_WIDTH(DIR_WIDTH)
) u_spcd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Steering PD with corner detection: self-checking testbench
// Streams frames of middle and far direction error into the block and checks
// every result beat against a cycle-free predictor of the filters, the corner
// hysteresis and the clamped, slew-limited PD angle. The register set is
// changed between phases while the block is idle, and both stream sides idle
// and stall at random.
// ----------------------------------------------------------------------------

module testbench;

	localparam int DIR_W      = 12;
	localparam int GAIN_FRAC  = 8;
	localparam int MID_TAPS   = 5;
	localparam int FAR_TAPS   = 10;
	localparam int IN_W       = 24;
	localparam int OUT_W      = 72;
	localparam int LATENCY    = 4;
	localparam int STALL_LEN  = 80;
	localparam int PHASE_LEN  = 250;
	localparam int REG_W[8]   = '{spcd_pkg::THRESH_W, spcd_pkg::GAIN_W, spcd_pkg::GAIN_W,
		spcd_pkg::GAIN_W, spcd_pkg::LIMIT_W, spcd_pkg::LIMIT_W, spcd_pkg::THRESH_W,
		spcd_pkg::THRESH_W};
	localparam int EDGE_VALS[5] = '{-2048, -1, 0, 1, 2047};

	// One result beat, laid out as on m_tdata (first member is the top bits).
	typedef struct packed {
		logic [12:0]      far_slow_diff;
		logic [11:0]      far_filtered;
		logic [12:0]      mid_filtered_diff;
		logic [11:0]      mid_filtered;
		spcd_pkg::scale_t integral_scale;
		logic             in_corner;
		logic [15:0]      steer_angle;
	} steer_result_t;

	// Predicts the result of each frame and checks the beats in order.
	class steer_scoreboard;
		int dead_zone, kp_straight, kp_corner, kd_gain;
		int angle_limit, angle_slew, enter_thr, exit_thr;
		int mid_hist[MID_TAPS];
		int far_hist[FAR_TAPS];
		int mid_mean_prev, far_mean_prev, far_slow_prev, angle_prev;
		bit corner;
		steer_result_t expected_q[$];
		int errors;

		function new();
			dead_zone   = spcd_pkg::DEAD_ZONE_RST;
			kp_straight = spcd_pkg::KP_STRAIGHT_RST;
			kp_corner   = spcd_pkg::KP_CORNER_RST;
			kd_gain     = spcd_pkg::KD_GAIN_RST;
			angle_limit = spcd_pkg::ANGLE_LIMIT_RST;
			angle_slew  = spcd_pkg::ANGLE_SLEW_RST;
			enter_thr   = spcd_pkg::ENTER_THR_RST;
			exit_thr    = spcd_pkg::EXIT_THR_RST;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Register write; bits above the register width are dropped.
		function void write_reg(spcd_pkg::cfg_reg_t idx, logic [15:0] value);
			int masked;
			masked = int'(value) & ((1 << REG_W[idx]) - 1);
			case (idx)
				spcd_pkg::REG_DEAD_ZONE:   dead_zone   = masked;
				spcd_pkg::REG_KP_STRAIGHT: kp_straight = masked;
				spcd_pkg::REG_KP_CORNER:   kp_corner   = masked;
				spcd_pkg::REG_KD_GAIN:     kd_gain     = masked;
				spcd_pkg::REG_ANGLE_LIMIT: angle_limit = masked;
				spcd_pkg::REG_ANGLE_SLEW:  angle_slew  = masked;
				spcd_pkg::REG_ENTER_THR:   enter_thr   = masked;
				spcd_pkg::REG_EXIT_THR:    exit_thr    = masked;
				default:                   ;
			endcase
		endfunction

		// Accepted frame: update the histories and queue the expected result.
		function void note_frame(logic signed [11:0] mid, logic signed [11:0] far);
			int total, old_total, mid_mean, mid_diff, far_mean, far_diff;
			int far_slow, slow_diff, mid_i, err;
			longint acc, angle;
			steer_result_t r;
			for (int i = MID_TAPS - 1; i > 0; i--)
				mid_hist[i] = mid_hist[i-1];
			mid_hist[0] = mid;
			for (int i = FAR_TAPS - 1; i > 0; i--)
				far_hist[i] = far_hist[i-1];
			far_hist[0] = far;

			// Means truncate toward zero, as signed integer division does.
			total = 0;
			for (int i = 0; i < MID_TAPS; i++)
				total += mid_hist[i];
			mid_mean = total / 5;
			mid_diff = mid_mean - mid_mean_prev;
			mid_mean_prev = mid_mean;

			total = 0;
			old_total = 0;
			for (int i = 0; i < 5; i++) begin
				total += far_hist[i];
				old_total += far_hist[i+5];
			end
			far_mean = total / 5;
			far_diff = far_mean - far_mean_prev;
			far_mean_prev = far_mean;
			far_slow = far_mean / 2 + old_total / 10;
			slow_diff = far_slow - far_slow_prev;
			far_slow_prev = far_slow;

			// Corner hysteresis on the far mean and its direction of change.
			r.integral_scale = spcd_pkg::SCALE_NONE;
			if (!corner) begin
				if ((far_diff > 0 && far_mean > enter_thr) ||
						(far_diff < 0 && far_mean < -enter_thr)) begin
					corner = 1'b1;
					r.integral_scale = spcd_pkg::SCALE_DIV3;
				end
			end else begin
				if ((far_diff < 0 && far_mean < exit_thr && far_mean > 0) ||
						(far_diff > 0 && far_mean > -exit_thr && far_mean < 0)) begin
					corner = 1'b0;
					r.integral_scale = spcd_pkg::SCALE_MUL3;
				end
			end

			// Dead zone pulls the raw middle error toward zero.
			mid_i = mid;
			if ((mid_i < 0 ? -mid_i : mid_i) >= dead_zone)
				err = (mid_i > 0) ? mid_i - dead_zone : mid_i + dead_zone;
			else
				err = 0;

			// PD with Q8.8 gains, then clamp and slew limit.
			acc = longint'(err) * longint'(corner ? kp_corner : kp_straight)
				+ longint'(mid_diff) * longint'(kd_gain);
			angle = acc / (longint'(1) << GAIN_FRAC);
			if (angle > angle_limit)
				angle = angle_limit;
			else if (angle < -angle_limit)
				angle = -angle_limit;
			if (angle - angle_prev > angle_slew)
				angle = angle_prev + angle_slew;
			else if (angle_prev - angle > angle_slew)
				angle = angle_prev - angle_slew;
			angle_prev = int'(angle);

			r.steer_angle       = angle[15:0];
			r.in_corner         = corner;
			r.mid_filtered      = mid_mean[11:0];
			r.mid_filtered_diff = mid_diff[12:0];
			r.far_filtered      = far_mean[11:0];
			r.far_slow_diff     = slow_diff[12:0];
			expected_q.push_back(r);
		endfunction

		function void compare_field(string name, longint want, longint got);
			if (want != got) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		// Result beat: compare field by field with the oldest expectation.
		function void check_result(logic [OUT_W-1:0] beat);
			steer_result_t want, got;
			if (expected_q.size() == 0) begin
				$error("result beat with no frame outstanding: %h", beat);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			got = beat[$bits(steer_result_t)-1:0];
			compare_field("steer_angle", $signed(want.steer_angle), $signed(got.steer_angle));
			compare_field("in_corner", want.in_corner, got.in_corner);
			compare_field("integral_scale", want.integral_scale, got.integral_scale);
			compare_field("mid_filtered", $signed(want.mid_filtered),
				$signed(got.mid_filtered));
			compare_field("mid_filtered_diff", $signed(want.mid_filtered_diff),
				$signed(got.mid_filtered_diff));
			compare_field("far_filtered", $signed(want.far_filtered),
				$signed(got.far_filtered));
			compare_field("far_slow_diff", $signed(want.far_slow_diff),
				$signed(got.far_slow_diff));
		endfunction
	endclass

	logic                             clk       = 1'b0;
	logic                             arst_n    = 1'b0;
	logic                             s_tvalid  = 1'b0;
	logic                             s_tready;
	logic [IN_W-1:0]                  s_tdata   = '0;
	logic                             m_tvalid;
	logic                             m_tready  = 1'b0;
	logic [OUT_W-1:0]                 m_tdata;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [spcd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [spcd_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

	steer_scoreboard sb;
	int  tx_idle_pct = 16;
	int  rx_idle_pct = 54;
	bit  stall_req   = 1'b0;
	bit  stall_ack   = 1'b0;
	int  stall_left  = 0;
	int  mid_walk, far_walk, mid_drift, far_drift;

	steering_pd_with_corner_detect i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// Watchdog for a hung handshake.
	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Receiver: random back pressure, plus a long hold-off on request.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stall_req != stall_ack) begin
			stall_ack  <= stall_req;
			stall_left <= STALL_LEN;
			m_tready   <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// Every result beat goes to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	// Offer one frame, wait until it is taken, then maybe leave a gap.
	task automatic send_frame(input logic signed [11:0] mid, input logic signed [11:0] far);
		s_tdata  <= {far, mid};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_frame(mid, far);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Stop sending and wait until every expected result has arrived.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// Write all eight registers; narrow ones get junk in the unused top bits.
	task automatic write_regs(input int vals[8]);
		logic [15:0] data;
		for (int i = 0; i < 8; i++) begin
			data = vals[i][15:0];
			if (REG_W[i] < 16)
				data = data | (16'($urandom_range(0, 65535)) & ~16'((1 << REG_W[i]) - 1));
			cfg_valid <= 1'b1;
			cfg_index <= spcd_pkg::cfg_reg_t'(i);
			cfg_data  <= data;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			sb.write_reg(spcd_pkg::cfg_reg_t'(i), data);
		end
		cfg_valid <= 1'b0;
	endtask

	// Mostly drifting trajectories so the corner flag toggles; some noise and extremes.
	function automatic logic [IN_W-1:0] next_frame();
		int pick, ev_m, ev_f;
		logic [11:0] m, f;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			if ($urandom_range(0, 15) == 0)
				far_drift = int'($urandom_range(0, 240)) - 120;
			if ($urandom_range(0, 15) == 0)
				mid_drift = int'($urandom_range(0, 160)) - 80;
			far_walk = far_walk + far_drift + int'($urandom_range(0, 200)) - 100;
			mid_walk = mid_walk + mid_drift + int'($urandom_range(0, 200)) - 100;
			if (far_walk > 2047 || far_walk < -2048) begin
				far_walk  = (far_walk > 0) ? 2047 : -2048;
				far_drift = -far_drift;
			end
			if (mid_walk > 2047 || mid_walk < -2048) begin
				mid_walk  = (mid_walk > 0) ? 2047 : -2048;
				mid_drift = -mid_drift;
			end
			m = mid_walk[11:0];
			f = far_walk[11:0];
		end else if (pick < 90) begin
			m = 12'($urandom_range(0, 4095));
			f = 12'($urandom_range(0, 4095));
		end else begin
			ev_m = EDGE_VALS[$urandom_range(0, 4)];
			ev_f = EDGE_VALS[$urandom_range(0, 4)];
			m = ev_m[11:0];
			f = ev_f[11:0];
		end
		return {f, m};
	endfunction

	// A run of random frames with one long receiver stall and one full pause.
	task automatic run_phase(input int count);
		logic [IN_W-1:0] frame;
		for (int n = 0; n < count; n++) begin
			frame = next_frame();
			send_frame(frame[11:0], frame[23:12]);
			if (n == count / 3)
				stall_req <= ~stall_req;
			if (n == 2 * count / 3)
				drain();
		end
		drain();
	endtask

	// Random register set biased to values where corners and clamps happen.
	task automatic random_regs();
		int vals[8];
		vals[spcd_pkg::REG_DEAD_ZONE]   = $urandom_range(0, 300);
		vals[spcd_pkg::REG_KP_STRAIGHT] = $urandom_range(0, 1500);
		vals[spcd_pkg::REG_KP_CORNER]   = $urandom_range(0, 1500);
		vals[spcd_pkg::REG_KD_GAIN]     = $urandom_range(0, 3000);
		vals[spcd_pkg::REG_ANGLE_LIMIT] = $urandom_range(1, 5000);
		vals[spcd_pkg::REG_ANGLE_SLEW]  = $urandom_range(0, 3000);
		vals[spcd_pkg::REG_ENTER_THR]   = $urandom_range(0, 700);
		vals[spcd_pkg::REG_EXIT_THR]    = $urandom_range(0, 700);
		write_regs(vals);
	endtask

	initial begin
		sb = new();
		mid_walk = 0;
		far_walk = 0;
		mid_drift = 40;
		far_drift = 60;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Field extremes at the reset register values.
		send_frame(2047, 2047);
		send_frame(-2048, -2048);
		send_frame(0, 0);
		send_frame(-1, 1);
		drain();

		// Dead zone edges, clamp and slew, then entering and leaving corners
		// on the positive and on the negative side.
		write_regs('{100, 512, 128, 300, 500, 50, 200, 100});
		send_frame(99, 300);
		send_frame(100, 600);
		send_frame(101, 900);
		send_frame(-99, 1200);
		send_frame(-100, 1200);
		send_frame(-101, 1200);
		send_frame(2047, 400);
		send_frame(2047, 0);
		send_frame(-2048, 0);
		send_frame(-2048, 0);
		send_frame(0, 0);
		send_frame(0, -300);
		send_frame(300, -600);
		send_frame(-300, -900);
		send_frame(1000, -1200);
		send_frame(-1000, -400);
		send_frame(0, 0);
		send_frame(0, 0);
		send_frame(0, 0);
		send_frame(0, 0);
		drain();

		// Random phases: sender lightly idle and receiver heavily idle first.
		random_regs();
		run_phase(PHASE_LEN);
		write_regs('{2047, 65535, 65535, 65535, 32767, 32767, 2047, 2047});
		run_phase(PHASE_LEN);
		// All-zero registers: zero angle limit and zero slew.
		write_regs('{0, 0, 0, 0, 0, 0, 0, 0});
		run_phase(PHASE_LEN);

		// Then the other way round.
		tx_idle_pct = 54;
		rx_idle_pct = 16;
		random_regs();
		run_phase(PHASE_LEN);
		random_regs();
		run_phase(PHASE_LEN);

		// Then no idling on either side.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_regs('{0, 65535, 256, 1024, 32767, 32767, 0, 0});
		run_phase(PHASE_LEN);
		random_regs();
		run_phase(PHASE_LEN);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
